[rtl/itp_pkg.sv]
// Shared types, codes and precedence functions of the infix-to-postfix converter.
package itp_pkg;

    localparam int VAL_BITS = 64;

    typedef logic [2:0] t_code;
    typedef logic [2:0] t_action;
    typedef logic [1:0] t_kind;

    localparam t_action ACT_OPERAND  = 3'd0;
    localparam t_action ACT_OPERATOR = 3'd1;
    localparam t_action ACT_LPAREN   = 3'd2;
    localparam t_action ACT_RPAREN   = 3'd3;
    localparam t_action ACT_END      = 3'd4;

    localparam t_code OP_PLUS    = 3'd0;
    localparam t_code OP_MINUS   = 3'd1;
    localparam t_code OP_TIMES   = 3'd2;
    localparam t_code OP_DIVIDE  = 3'd3;
    localparam t_code OP_POWER   = 3'd4;
    localparam t_code OP_MODULO  = 3'd5;
    localparam t_code OP_FACT    = 3'd6;
    localparam t_code CODE_LPAREN = 3'd7;

    localparam t_kind KIND_OPERAND  = 2'd0;
    localparam t_kind KIND_OPERATOR = 2'd1;
    localparam t_kind KIND_ERROR    = 2'd2;
    localparam t_kind KIND_DONE     = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RD,
        S_EVAL,
        S_PUSH,
        S_DONE
    } t_state;

    // stack write port
    typedef struct packed {
        logic  en;
        t_code data;
    } t_stk_wr;

    // smaller number binds tighter
    function automatic logic [2:0] prec_of(input t_code code);
        logic [2:0] p;
        case (code)
            OP_FACT:                       p = 3'd2;
            OP_POWER:                      p = 3'd3;
            OP_TIMES, OP_DIVIDE, OP_MODULO: p = 3'd4;
            OP_PLUS, OP_MINUS:             p = 3'd5;
            default:                       p = 3'd1;
        endcase
        return p;
    endfunction

    // '%' and '!' are right-associative
    function automatic logic left_assoc(input t_code code);
        return (code <= OP_POWER);
    endfunction

endpackage

[rtl/itp_in_if.sv]
// Token input channel: valid/ready handshake with one token word.
interface itp_in_if import itp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [2:0]          action;
    logic [2:0]          op_code;
    logic [VAL_BITS-1:0] operand_value;

    modport source (output valid, action, op_code, operand_value, input ready);
    modport sink   (input valid, action, op_code, operand_value, output ready);
endinterface

// Result output channel: valid/ready handshake with one postfix word.
interface itp_out_if import itp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          kind;
    logic [2:0]          out_op_code;
    logic [VAL_BITS-1:0] out_value;
    logic                last;

    modport source (output valid, kind, out_op_code, out_value, last, input ready);
    modport sink   (input valid, kind, out_op_code, out_value, last, output ready);
endinterface

[rtl/itp_stack.sv]
// Operator stack memory: one write port, one registered read port.
module itp_stack import itp_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  t_stk_wr       i_wr,
    input  logic [AW-1:0] i_wr_addr,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_code         o_rd_data
);

    t_code r_mem [DEPTH];
    t_code r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr_addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/itp_prec_cmp.sv]
// Precedence/associativity compare: decides whether the stack top pops.
module itp_prec_cmp import itp_pkg::*; (
    input  t_code i_in_code,
    input  t_code i_top_code,
    output logic  o_pop
);

    logic [2:0] w_p_in;
    logic [2:0] w_p_top;

    assign w_p_in  = prec_of(i_in_code);
    assign w_p_top = prec_of(i_top_code);

    assign o_pop = (i_top_code != CODE_LPAREN) &&
                   (left_assoc(i_in_code) ? (w_p_in >= w_p_top) : (w_p_in > w_p_top));

endmodule

[rtl/infix_to_postfix_converter_core.sv]
// Top level of the shunting-yard infix-to-postfix converter.
//
// Usage:
//   i_tok carries one token word per handshake (action, op_code, operand_value).
//   o_res carries postfix words (kind, out_op_code, out_value, last); the final
//   word caused by a token has last set. Tokens that cause nothing (ignored
//   actions, anything but end while an error is pending) produce no word.
// Sequencing: operands, ignored tokens, decode errors and an end with nothing
//   to flush finish in decode; a left paren or a push onto an empty stack
//   adds a push step; operators, right parens and an end with no paren open
//   examine stack entries in turn, each with a registered stack read and a
//   pass through the one shared compare unit. A word reaches o_res in the
//   cycle after it is made.
// Output: one result register. A new token is taken while the last word of
//   the previous one still waits there; a stalled receiver only holds the
//   sequencer when it has another word to hand over.
// Reset: stack count, open-paren count, error flag and handshake state clear.
//   The stack memory itself is not cleared; entries above the count are
//   never read.
module infix_to_postfix_converter_core import itp_pkg::*; #(
    parameter int STACK_DEPTH = 16,
    parameter int VALUE_WIDTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    itp_in_if.sink    i_tok,
    itp_out_if.source o_res
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // sequencer and token latch
    t_state                 r_state, n_state;
    t_action                r_action, n_action;
    t_code                  r_code, n_code;
    logic [VALUE_WIDTH-1:0] r_value, n_value;

    // stack bookkeeping; r_parens counts left parens on the stack
    logic [CW-1:0]          r_count, n_count;
    logic [CW-1:0]          r_parens, n_parens;
    logic                   r_error, n_error;

    // popped operator held back until we know whether it is the last word
    logic                   r_pend_valid, n_pend_valid;
    t_code                  r_pend_op, n_pend_op;

    // output register
    logic                   r_out_valid, n_out_valid;
    t_kind                  r_out_kind, n_out_kind;
    t_code                  r_out_op, n_out_op;
    logic [VALUE_WIDTH-1:0] r_out_value, n_out_value;
    logic                   r_out_last, n_out_last;

    // emit request from the output logic
    logic                   w_emit;
    t_kind                  w_e_kind;
    t_code                  w_e_op;
    logic [VALUE_WIDTH-1:0] w_e_value;
    logic                   w_e_last;
    logic                   w_slot_free;
    logic                   w_stall;
    logic                   w_accept;

    // stack port and compare unit
    t_stk_wr                w_wr;
    logic [AW-1:0]          w_wr_addr;
    logic                   w_rd_en;
    logic [AW-1:0]          w_rd_addr;
    t_code                  w_top;
    logic                   w_pop;
    t_code                  w_push_code;
    logic [CW-1:0]          w_count_m1;

    itp_stack #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_wr_addr (w_wr_addr),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_top)
    );

    itp_prec_cmp u_cmp (
        .i_in_code  (r_code),
        .i_top_code (w_top),
        .o_pop      (w_pop)
    );

    assign w_accept    = i_tok.valid && i_tok.ready;
    assign w_slot_free = !r_out_valid || o_res.ready;
    assign w_stall     = w_emit && !w_slot_free;
    assign w_count_m1  = r_count - CW'(1);
    assign w_push_code = (r_action == ACT_LPAREN) ? CODE_LPAREN : r_code;

    assign i_tok.ready       = (r_state == S_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.kind        = r_out_kind;
    assign o_res.out_op_code = r_out_op;
    assign o_res.out_value   = VAL_BITS'(r_out_value);
    assign o_res.last        = r_out_last;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!w_stall) begin
                    if (r_action == ACT_END) begin
                        if (r_error || r_count == '0) begin
                            n_state = S_IDLE;
                        end else if (r_parens != '0) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_RD;
                        end
                    end else if (r_error || r_action > ACT_END) begin
                        n_state = S_IDLE;
                    end else if (r_action == ACT_OPERATOR) begin
                        if (r_code == CODE_LPAREN) begin
                            n_state = S_IDLE;
                        end else if (r_count == '0) begin
                            n_state = S_PUSH;
                        end else begin
                            n_state = S_RD;
                        end
                    end else if (r_action == ACT_LPAREN) begin
                        n_state = S_PUSH;
                    end else if (r_action == ACT_RPAREN) begin
                        n_state = (r_parens == '0) ? S_IDLE : S_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_RD: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (!w_stall) begin
                    case (r_action)
                        ACT_OPERATOR: begin
                            if (w_pop && r_count != CW'(1)) begin
                                n_state = S_RD;
                            end else begin
                                n_state = S_PUSH;
                            end
                        end
                        ACT_RPAREN: begin
                            n_state = (w_top == CODE_LPAREN) ? S_IDLE : S_RD;
                        end
                        ACT_END: begin
                            n_state = (r_count == CW'(1)) ? S_DONE : S_RD;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_PUSH: begin
                if (!w_stall) begin
                    n_state = S_IDLE;
                end
            end
            S_DONE: begin
                if (!w_stall && !r_pend_valid) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath, stack port and emit requests
    always_comb begin
        n_action     = r_action;
        n_code       = r_code;
        n_value      = r_value;
        n_count      = r_count;
        n_parens     = r_parens;
        n_error      = r_error;
        n_pend_valid = r_pend_valid;
        n_pend_op    = r_pend_op;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_kind   = r_out_kind;
        n_out_op     = r_out_op;
        n_out_value  = r_out_value;
        n_out_last   = r_out_last;
        w_emit       = 1'b0;
        w_e_kind     = KIND_OPERATOR;
        w_e_op       = r_pend_op;
        w_e_value    = '0;
        w_e_last     = 1'b0;
        w_wr         = '{en: 1'b0, data: w_push_code};
        w_wr_addr    = r_count[AW-1:0];
        w_rd_en      = 1'b0;
        w_rd_addr    = w_count_m1[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_action = i_tok.action;
                    n_code   = i_tok.op_code;
                    n_value  = i_tok.operand_value[VALUE_WIDTH-1:0];
                end
            end
            S_DECODE: begin
                if (r_action == ACT_END) begin
                    if (r_error || r_count == '0) begin
                        w_emit   = 1'b1;
                        w_e_kind = KIND_DONE;
                        w_e_op   = '0;
                        w_e_last = 1'b1;
                        if (w_slot_free) begin
                            n_count  = '0;
                            n_parens = '0;
                            n_error  = 1'b0;
                        end
                    end else if (r_parens != '0) begin
                        // unmatched left paren: error, then done from S_DONE
                        w_emit   = 1'b1;
                        w_e_kind = KIND_ERROR;
                        w_e_op   = '0;
                    end
                end else if (!r_error && r_action == ACT_OPERAND) begin
                    w_emit    = 1'b1;
                    w_e_kind  = KIND_OPERAND;
                    w_e_op    = '0;
                    w_e_value = r_value;
                    w_e_last  = 1'b1;
                end else if (!r_error && ((r_action == ACT_OPERATOR && r_code == CODE_LPAREN)
                                       || (r_action == ACT_RPAREN && r_parens == '0))) begin
                    w_emit   = 1'b1;
                    w_e_kind = KIND_ERROR;
                    w_e_op   = '0;
                    w_e_last = 1'b1;
                    if (w_slot_free) begin
                        n_error = 1'b1;
                    end
                end
            end
            S_RD: begin
                w_rd_en = 1'b1;
            end
            S_EVAL: begin
                if (r_action == ACT_RPAREN && w_top == CODE_LPAREN) begin
                    // matching paren: drop it, the held operator is the last word
                    w_emit   = r_pend_valid;
                    w_e_last = 1'b1;
                    if (w_slot_free || !r_pend_valid) begin
                        n_count      = w_count_m1;
                        n_parens     = r_parens - CW'(1);
                        n_pend_valid = 1'b0;
                    end
                end else if (r_action != ACT_OPERATOR || w_pop) begin
                    w_emit = r_pend_valid;
                    if (w_slot_free || !r_pend_valid) begin
                        n_count      = w_count_m1;
                        n_pend_valid = 1'b1;
                        n_pend_op    = w_top;
                    end
                end
            end
            S_PUSH: begin
                if (r_pend_valid) begin
                    // something was popped, so the push fits
                    w_emit   = 1'b1;
                    w_e_last = 1'b1;
                    if (w_slot_free) begin
                        w_wr.en      = 1'b1;
                        n_count      = r_count + CW'(1);
                        n_pend_valid = 1'b0;
                    end
                end else if (r_count >= CW'(STACK_DEPTH)) begin
                    w_emit   = 1'b1;
                    w_e_kind = KIND_ERROR;
                    w_e_op   = '0;
                    w_e_last = 1'b1;
                    if (w_slot_free) begin
                        n_error = 1'b1;
                    end
                end else begin
                    w_wr.en = 1'b1;
                    n_count = r_count + CW'(1);
                    if (r_action == ACT_LPAREN) begin
                        n_parens = r_parens + CW'(1);
                    end
                end
            end
            S_DONE: begin
                w_emit = 1'b1;
                if (r_pend_valid) begin
                    if (w_slot_free) begin
                        n_pend_valid = 1'b0;
                    end
                end else begin
                    w_e_kind = KIND_DONE;
                    w_e_op   = '0;
                    w_e_last = 1'b1;
                    if (w_slot_free) begin
                        n_count  = '0;
                        n_parens = '0;
                        n_error  = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase

        if (w_emit && w_slot_free) begin
            n_out_valid = 1'b1;
            n_out_kind  = w_e_kind;
            n_out_op    = w_e_op;
            n_out_value = w_e_value;
            n_out_last  = w_e_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_parens     <= '0;
            r_error      <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_parens     <= n_parens;
            r_error      <= n_error;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action    <= n_action;
        r_code      <= n_code;
        r_value     <= n_value;
        r_pend_op   <= n_pend_op;
        r_out_kind  <= n_out_kind;
        r_out_op    <= n_out_op;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
    end

`ifndef ASSERT_OFF
    a_parens_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_parens <= r_count)
        else $error("open-paren count exceeds stack count");

    a_count_le_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_pend_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_state != S_IDLE && r_state != S_DECODE))
        else $error("held operator left behind at end of token");

    a_eval_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> ($past(r_state) == S_RD || $past(r_state) == S_EVAL))
        else $error("stack top compared without a read");

    a_no_emit_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |=> $stable(r_out_kind) && $stable(r_out_last))
        else $error("pending result word overwritten");
`endif

endmodule

[tb/postfix_checker.sv]
`timescale 1ns / 100ps
// Postfix word checker: predicts the converter's output words from accepted tokens and compares.
module postfix_checker import itp_pkg::*; #(
    parameter int STACK_DEPTH = 16,
    parameter int VALUE_WIDTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_tok_valid,
    input  logic                i_tok_ready,
    input  t_action             i_tok_action,
    input  t_code               i_tok_op_code,
    input  logic [VAL_BITS-1:0] i_tok_operand_value,
    input  logic                i_res_valid,
    input  logic                i_res_ready,
    input  t_kind               i_res_kind,
    input  t_code               i_res_out_op_code,
    input  logic [VAL_BITS-1:0] i_res_out_value,
    input  logic                i_res_last,
    output int                  o_mismatch_count,
    output int                  o_words_pending
);

    localparam t_code NO_CODE = '0;
    localparam logic [VAL_BITS-1:0] VALUE_MASK =
        (VALUE_WIDTH >= VAL_BITS) ? '1 : ((VAL_BITS'(1) << VALUE_WIDTH) - 1);

    typedef struct packed {
        t_kind               kind;
        t_code               op_code;
        logic [VAL_BITS-1:0] value;
        logic                last;
    } t_word;

    t_word expected_words[$];
    t_code op_stack[STACK_DEPTH];
    int    stack_depth;
    bit    error_pending;
    int    mismatches;

    assign o_mismatch_count = mismatches;

    // smaller rank binds tighter
    function automatic int bind_rank(t_code code);
        case (code)
            OP_FACT:                        return 2;
            OP_POWER:                       return 3;
            OP_TIMES, OP_DIVIDE, OP_MODULO: return 4;
            OP_PLUS, OP_MINUS:              return 5;
            default:                        return 1;
        endcase
    endfunction

    function automatic void add_word(t_kind kind, t_code code, logic [VAL_BITS-1:0] value);
        t_word w;
        w.kind    = kind;
        w.op_code = code;
        w.value   = value;
        w.last    = 1'b0;
        expected_words.insert(expected_words.size(), w);
    endfunction

    function automatic void raise_error();
        error_pending = 1'b1;
        add_word(KIND_ERROR, NO_CODE, '0);
    endfunction

    function automatic bit paren_open();
        bit found;
        found = 1'b0;
        for (int i = 0; i < stack_depth; i++)
            if (op_stack[i] == CODE_LPAREN) found = 1'b1;
        return found;
    endfunction

    function automatic void predict_postfix(t_action act, t_code code,
                                            logic [VAL_BITS-1:0] value);
        int first;
        int rank;
        bit left;
        first = expected_words.size();
        if (act == ACT_END) begin
            if (!error_pending) begin
                if (paren_open()) begin
                    add_word(KIND_ERROR, NO_CODE, '0);
                end else begin
                    while (stack_depth > 0) begin
                        stack_depth--;
                        add_word(KIND_OPERATOR, op_stack[stack_depth], '0);
                    end
                end
            end
            stack_depth   = 0;
            error_pending = 1'b0;
            add_word(KIND_DONE, NO_CODE, '0);
        end else if (!error_pending && act < ACT_END) begin
            case (act)
                ACT_OPERAND: begin
                    add_word(KIND_OPERAND, NO_CODE, value & VALUE_MASK);
                end
                ACT_OPERATOR: begin
                    if (code == CODE_LPAREN) begin
                        raise_error();
                    end else begin
                        rank = bind_rank(code);
                        left = (code <= OP_POWER);
                        while (stack_depth > 0 && op_stack[stack_depth-1] != CODE_LPAREN &&
                               (left ? rank >= bind_rank(op_stack[stack_depth-1])
                                     : rank >  bind_rank(op_stack[stack_depth-1]))) begin
                            stack_depth--;
                            add_word(KIND_OPERATOR, op_stack[stack_depth], '0);
                        end
                        if (stack_depth >= STACK_DEPTH) begin
                            raise_error();
                        end else begin
                            op_stack[stack_depth] = code;
                            stack_depth++;
                        end
                    end
                end
                ACT_LPAREN: begin
                    if (stack_depth >= STACK_DEPTH) begin
                        raise_error();
                    end else begin
                        op_stack[stack_depth] = CODE_LPAREN;
                        stack_depth++;
                    end
                end
                default: begin
                    // right paren
                    if (!paren_open()) begin
                        raise_error();
                    end else begin
                        while (op_stack[stack_depth-1] != CODE_LPAREN) begin
                            stack_depth--;
                            add_word(KIND_OPERATOR, op_stack[stack_depth], '0);
                        end
                        stack_depth--;
                    end
                end
            endcase
        end
        if (expected_words.size() > first)
            expected_words[expected_words.size()-1].last = 1'b1;
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        $display("checker: %0t ns: %s", $time, what);
    endtask

    task automatic check_word();
        t_word w;
        if (expected_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word, kind %0d", i_res_kind));
        end else begin
            w = expected_words.pop_front();
            if (i_res_kind != w.kind)
                report_mismatch($sformatf("kind %0d, want %0d", i_res_kind, w.kind));
            if (i_res_out_op_code != w.op_code)
                report_mismatch($sformatf("op code %0d, want %0d",
                                          i_res_out_op_code, w.op_code));
            if (i_res_out_value != w.value)
                report_mismatch($sformatf("value %h, want %h", i_res_out_value, w.value));
            if (i_res_last != w.last)
                report_mismatch($sformatf("last %0d, want %0d", i_res_last, w.last));
        end
    endtask

    // words out are checked before tokens in: a token can never cause a word
    // on the edge that accepts it
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_words.delete();
            stack_depth   = 0;
            error_pending = 1'b0;
            mismatches    = 0;
        end else begin
            if (i_res_valid && i_res_ready)
                check_word();
            if (i_tok_valid && i_tok_ready)
                predict_postfix(i_tok_action, i_tok_op_code, i_tok_operand_value);
        end
        o_words_pending <= expected_words.size();
    end

endmodule

[tb/infix_to_postfix_converter_core_tb.sv]
`timescale 1ns / 100ps
// Testbench top: drives token words, back-pressures the output and gives the verdict.
module infix_to_postfix_converter_core_tb;
    import itp_pkg::*;

    localparam t_action ACT_LAST_CODE = '1;

    logic i_clk;
    logic i_rst_n;

    itp_in_if  tok_if();
    itp_out_if res_if();

    int mismatch_count;
    int words_pending;
    int tokens_sent;     // tokens with a meaningful action, accepted so far
    int tx_idle_pct;     // only read by the stimulus process
    int rx_idle_pct;
    bit rx_hold;

    infix_to_postfix_converter_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (tok_if),
        .o_res   (res_if)
    );

    postfix_checker u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_tok_valid         (tok_if.valid),
        .i_tok_ready         (tok_if.ready),
        .i_tok_action        (tok_if.action),
        .i_tok_op_code       (tok_if.op_code),
        .i_tok_operand_value (tok_if.operand_value),
        .i_res_valid         (res_if.valid),
        .i_res_ready         (res_if.ready),
        .i_res_kind          (res_if.kind),
        .i_res_out_op_code   (res_if.out_op_code),
        .i_res_out_value     (res_if.out_value),
        .i_res_last          (res_if.last),
        .o_mismatch_count    (mismatch_count),
        .o_words_pending     (words_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop. Worst case is far below this: ~400 tokens, each with its
    // sequencer steps plus up to 17 words under a 51% receiver stall.
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // Receiver: held off in reset, random stalls, or a solid hold-off while
    // rx_hold is set.
    always @(posedge i_clk) begin
        if (!i_rst_n || rx_hold) begin
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Operand bits: mostly random, with the all-zero and all-one extremes.
    function automatic logic [VAL_BITS-1:0] rand_value();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // One token word. The sender may idle a random number of cycles first;
    // valid then stays up until the handshake completes.
    task automatic send_token(t_action act, t_code code, logic [VAL_BITS-1:0] value);
        while ($urandom_range(99) < tx_idle_pct) begin
            tok_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        tok_if.valid         <= 1'b1;
        tok_if.action        <= act;
        tok_if.op_code       <= code;
        tok_if.operand_value <= value;
        @(posedge i_clk);
        while (!tok_if.ready) @(posedge i_clk);
        if (act <= ACT_END) tokens_sent++;
    endtask

    // Fields that the token kind ignores still carry random bits.
    task automatic put_operand(logic [VAL_BITS-1:0] value);
        send_token(ACT_OPERAND, t_code'($urandom_range(7)), value);
    endtask

    task automatic put_op(t_code code);
        send_token(ACT_OPERATOR, code, rand_value());
    endtask

    task automatic put_mark(t_action act);
        send_token(act, t_code'($urandom_range(7)), rand_value());
    endtask

    // Sender goes quiet until every predicted word has been seen. The first
    // edge lets the checker count a token accepted on the current edge.
    task automatic pause_until_drained();
        tok_if.valid <= 1'b0;
        @(posedge i_clk);
        while (words_pending != 0) @(posedge i_clk);
    endtask

    // One random expression. Most are well formed with random shape, so the
    // stack actually builds up; some nest deep enough to fill or overflow the
    // stack; the rest is raw noise that may or may not be closed by an end.
    task automatic send_expression();
        int mode;
        int terms;
        int opened;
        int levels;
        int noise_len;
        mode = $urandom_range(99);
        if (mode < 70) begin
            terms  = $urandom_range(1, 12);
            opened = 0;
            repeat (terms) begin
                while ($urandom_range(3) == 0) begin
                    put_mark(ACT_LPAREN);
                    opened++;
                end
                put_operand(rand_value());
                if ($urandom_range(4) == 0) put_op(OP_FACT);
                while (opened > 0 && $urandom_range(2) == 0) begin
                    put_mark(ACT_RPAREN);
                    opened--;
                end
                put_op(t_code'($urandom_range(OP_MODULO)));
            end
            put_operand(rand_value());
            repeat (opened) put_mark(ACT_RPAREN);
            put_mark(ACT_END);
        end else if (mode < 85) begin
            // each level stacks an operator and a left paren: 8 levels fill
            // the 16 entries exactly, 9 or more overflow
            levels = $urandom_range(4, 10);
            repeat (levels) begin
                put_operand(rand_value());
                if ($urandom_range(1) == 0)
                    put_op($urandom_range(1) ? OP_MODULO : OP_FACT);
                else
                    put_op(t_code'($urandom_range(OP_FACT)));
                put_mark(ACT_LPAREN);
            end
            put_operand(rand_value());
            repeat (levels) put_mark(ACT_RPAREN);
            put_mark(ACT_END);
        end else begin
            noise_len = $urandom_range(1, 10);
            repeat (noise_len)
                send_token(t_action'($urandom_range(7)), t_code'($urandom_range(7)),
                           rand_value());
            if ($urandom_range(3) != 0) put_mark(ACT_END);
        end
    endtask

    initial begin
        tok_if.valid         = 1'b0;
        tok_if.action        = ACT_OPERAND;
        tok_if.op_code       = OP_PLUS;
        tok_if.operand_value = '0;
        i_rst_n              = 1'b0;
        rx_hold              = 1'b0;
        tokens_sent          = 0;
        tx_idle_pct          = 30;
        rx_idle_pct          = 51;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Every operator and both parens: ( 0 + ~0 ) * c ^ d % e ! - f / g
        put_mark(ACT_LPAREN);
        put_operand('0);
        put_op(OP_PLUS);
        put_operand('1);
        put_mark(ACT_RPAREN);
        put_op(OP_TIMES);
        put_operand(rand_value());
        put_op(OP_POWER);
        put_operand(rand_value());
        put_op(OP_MODULO);
        put_operand(rand_value());
        put_op(OP_FACT);
        put_op(OP_MINUS);
        put_operand(rand_value());
        put_op(OP_DIVIDE);
        put_operand(rand_value());
        put_mark(ACT_END);
        // unmatched right paren; the operand after it is swallowed
        put_mark(ACT_RPAREN);
        put_operand(rand_value());
        put_mark(ACT_END);
        // operator with the paren code is an error
        put_op(CODE_LPAREN);
        put_mark(ACT_END);
        // unknown actions produce nothing
        for (int a = ACT_END + 1; a <= ACT_LAST_CODE; a++)
            put_mark(t_action'(a));
        // left paren still open at the end
        put_mark(ACT_LPAREN);
        put_operand(rand_value());
        put_mark(ACT_END);

        // Phase 1: sender idles 30%, receiver 51%.
        while (tokens_sent < 130) send_expression();
        pause_until_drained();

        // Phase 2: the other way round.
        tx_idle_pct = 51;
        rx_idle_pct <= 30;
        while (tokens_sent < 230) send_expression();
        pause_until_drained();

        // Phase 3: no idling. Open with a long receiver hold-off while the
        // sender keeps offering tokens, so the core backs up into its input.
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (300) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
            begin
                repeat (4) send_expression();
            end
        join
        while (tokens_sent < 330) send_expression();
        pause_until_drained();

        // tail: a token that causes nothing can still be in flight
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/itp_pkg.sv
rtl/itp_in_if.sv
rtl/itp_stack.sv
rtl/itp_prec_cmp.sv
rtl/infix_to_postfix_converter_core.sv
tb/postfix_checker.sv
tb/infix_to_postfix_converter_core_tb.sv
